@@ rtl/fraction_reduce_gcd_assert.svh @@
// assertion macros shared by the fraction reducer modules
`ifndef FRACTION_REDUCE_GCD_ASSERT_SVH
`define FRACTION_REDUCE_GCD_ASSERT_SVH

// same-cycle implication, checked outside reset
`define FRGCD_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("frgcd check failed");

// next-cycle implication, checked outside reset
`define FRGCD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("frgcd check failed");

`endif

@@ rtl/frgcd_pkg.sv @@
// shared types for the fraction reducer: controller states, command and status groups
`default_nettype none

package frgcd_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TEST,
    ST_REM,
    ST_QN,
    ST_QD,
    ST_EMIT
  } frgcd_state_t;

  typedef struct packed {
    logic load;
    logic start_rem;
    logic start_qn;
    logic start_qd;
    logic step;
    logic swap;
    logic keep_qn;
    logic emit;
  } frgcd_cmd_t;

  typedef struct packed {
    logic a_zero;
    logic b_zero;
    logic div_done;
    logic out_free;
  } frgcd_sts_t;

endpackage

`default_nettype wire

@@ rtl/fraction_reduce_gcd.sv @@
// top level of the signed fraction reducer
`default_nettype none

// Reduces a signed fraction by the Euclidean GCD of numerator and denominator,
// with truncating remainder and division, so the GCD and the outputs follow
// the signs of the inputs. Both inputs zero give zero outputs and zero_error.
// One request is handled at a time; a finished result waits in the output
// register while the next request is taken. All division runs on one shared
// restoring divider that retires one quotient bit per cycle: each request runs
// the remainder steps of the Euclid chain and then the two final divisions of
// the numerator and denominator magnitudes by the GCD, with the signs put back
// on the quotients afterwards.
module fraction_reduce_gcd #(
  parameter int VALUE_WIDTH = 32
) (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           in_valid,
  output logic                          in_stall,
  input  wire  signed [VALUE_WIDTH-1:0] in_num_in,
  input  wire  signed [VALUE_WIDTH-1:0] in_den_in,
  output logic                          out_valid,
  input  wire                           out_stall,
  output logic signed [VALUE_WIDTH-1:0] out_num_out,
  output logic signed [VALUE_WIDTH-1:0] out_den_out,
  output logic                          out_zero_error
);
  import frgcd_pkg::*;

  frgcd_cmd_t cmd;
  frgcd_sts_t sts;

  frgcd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  frgcd_dp #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .num_in     (in_num_in),
    .den_in     (in_den_in),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .num_out    (out_num_out),
    .den_out    (out_den_out),
    .zero_error (out_zero_error)
  );

endmodule

`default_nettype wire

@@ rtl/frgcd_dp.sv @@
// datapath of the fraction reducer: operand registers, shared restoring divider, result register
`default_nettype none

`include "fraction_reduce_gcd_assert.svh"

module frgcd_dp #(
  parameter int VALUE_WIDTH = 32
) (
  input  wire                           clk,
  input  wire                           rst_n,
  input  frgcd_pkg::frgcd_cmd_t         cmd,
  output frgcd_pkg::frgcd_sts_t         sts,
  input  wire  signed [VALUE_WIDTH-1:0] num_in,
  input  wire  signed [VALUE_WIDTH-1:0] den_in,
  output logic                          out_valid,
  input  wire                           out_stall,
  output logic signed [VALUE_WIDTH-1:0] num_out,
  output logic signed [VALUE_WIDTH-1:0] den_out,
  output logic                          zero_error
);
  import frgcd_pkg::*;

  localparam int CntW = $clog2(VALUE_WIDTH + 1);

  logic                   num_neg_r, den_neg_r;
  logic [VALUE_WIDTH-1:0] num_mag_r, den_mag_r;
  logic [VALUE_WIDTH-1:0] a_r, b_r;
  logic                   parity_r;
  logic [VALUE_WIDTH-1:0] rem_r, quo_r, dvs_r;
  logic [CntW-1:0]        cnt_r;
  logic [VALUE_WIDTH-1:0] qn_r;
  logic                   out_valid_r;
  logic [VALUE_WIDTH-1:0] num_out_r, den_out_r;
  logic                   zero_r;

  logic [VALUE_WIDTH-1:0] num_mag, den_mag;
  logic [VALUE_WIDTH:0]   rem_sh, diff;
  logic                   gcd_neg;
  logic [VALUE_WIDTH-1:0] qd_signed;

  // magnitudes fit unsigned even for the most negative pattern
  assign num_mag = num_in[VALUE_WIDTH-1] ? (-num_in) : num_in;
  assign den_mag = den_in[VALUE_WIDTH-1] ? (-den_in) : den_in;

  // one restoring step: shift in next dividend bit, try subtract
  assign rem_sh = {rem_r, quo_r[VALUE_WIDTH-1]};
  assign diff   = rem_sh - {1'b0, dvs_r};

  // odd chain positions carry the denominator's sign
  assign gcd_neg   = parity_r ? den_neg_r : num_neg_r;
  assign qd_signed = (den_neg_r ^ gcd_neg) ? (-quo_r) : quo_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      num_neg_r <= num_in[VALUE_WIDTH-1];
      den_neg_r <= den_in[VALUE_WIDTH-1];
      num_mag_r <= num_mag;
      den_mag_r <= den_mag;
      a_r       <= num_mag;
      b_r       <= den_mag;
      parity_r  <= 1'b0;
    end else if (cmd.swap) begin
      a_r      <= b_r;
      b_r      <= rem_r;
      parity_r <= ~parity_r;
    end

    if (cmd.start_rem || cmd.start_qn || cmd.start_qd) begin
      rem_r <= '0;
      if (cmd.start_rem) begin
        quo_r <= a_r;
        dvs_r <= b_r;
      end else if (cmd.start_qn) begin
        quo_r <= num_mag_r;
        dvs_r <= a_r;
      end else begin
        quo_r <= den_mag_r;
        dvs_r <= a_r;
      end
    end else if (cmd.step) begin
      if (!diff[VALUE_WIDTH]) begin
        rem_r <= diff[VALUE_WIDTH-1:0];
      end else begin
        rem_r <= rem_sh[VALUE_WIDTH-1:0];
      end
      quo_r <= {quo_r[VALUE_WIDTH-2:0], ~diff[VALUE_WIDTH]};
    end

    if (cmd.keep_qn) begin
      qn_r <= (num_neg_r ^ gcd_neg) ? (-quo_r) : quo_r;
    end

    if (cmd.emit) begin
      zero_r <= (a_r == '0);
      if (a_r == '0) begin
        num_out_r <= '0;
        den_out_r <= '0;
      end else begin
        num_out_r <= qn_r;
        den_out_r <= qd_signed;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.start_rem || cmd.start_qn || cmd.start_qd) begin
        cnt_r <= CntW'(VALUE_WIDTH);
      end else if (cmd.step) begin
        cnt_r <= cnt_r - CntW'(1);
      end

      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign sts.a_zero   = (a_r == '0);
  assign sts.b_zero   = (b_r == '0);
  assign sts.div_done = (cnt_r == '0);
  assign sts.out_free = !out_valid_r || !out_stall;

  assign out_valid  = out_valid_r;
  assign num_out    = num_out_r;
  assign den_out    = den_out_r;
  assign zero_error = zero_r;

  `FRGCD_ASSERT_NEXT(a_emit_shows, cmd.emit, out_valid_r)
  `FRGCD_ASSERT_IMP(a_step_counts, cmd.step, cnt_r != '0)
  `FRGCD_ASSERT_IMP(a_zero_outs, out_valid_r && zero_r, num_out_r == '0 && den_out_r == '0)

endmodule

`default_nettype wire

@@ rtl/frgcd_ctrl.sv @@
// controller of the fraction reducer: sequences remainder steps and the two final divisions
`default_nettype none

`include "fraction_reduce_gcd_assert.svh"

module frgcd_ctrl (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_valid,
  output logic                  in_stall,
  input  frgcd_pkg::frgcd_sts_t sts,
  output frgcd_pkg::frgcd_cmd_t cmd
);
  import frgcd_pkg::*;

  frgcd_state_t state_r, state_nxt;
  logic         in_take;

  assign in_stall = (state_r != ST_IDLE);
  assign in_take  = in_valid && (state_r == ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_TEST;
        end
      end
      ST_TEST: begin
        if (!sts.b_zero) begin
          cmd.start_rem = 1'b1;
          state_nxt     = ST_REM;
        end else if (sts.a_zero) begin
          state_nxt = ST_EMIT;
        end else begin
          cmd.start_qn = 1'b1;
          state_nxt    = ST_QN;
        end
      end
      ST_REM: begin
        if (!sts.div_done) begin
          cmd.step = 1'b1;
        end else begin
          cmd.swap  = 1'b1;
          state_nxt = ST_TEST;
        end
      end
      ST_QN: begin
        if (!sts.div_done) begin
          cmd.step = 1'b1;
        end else begin
          cmd.keep_qn  = 1'b1;
          cmd.start_qd = 1'b1;
          state_nxt    = ST_QD;
        end
      end
      ST_QD: begin
        if (!sts.div_done) begin
          cmd.step = 1'b1;
        end else begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  `FRGCD_ASSERT_NEXT(a_take_tests, in_take, state_r == ST_TEST)
  `FRGCD_ASSERT_IMP(a_emit_free, cmd.emit, sts.out_free)
  `FRGCD_ASSERT_IMP(a_swap_done, cmd.swap || cmd.keep_qn, sts.div_done && !cmd.step)

endmodule

`default_nettype wire
